[design/atc_pkg.sv]
// Shared types and codes for the affine transform composer.
package atc_pkg;

  // Operation codes carried in the func field of an input item
  localparam logic [4:0] FN_POINT    = 5'd0;
  localparam logic [4:0] FN_IDENT    = 5'd1;
  localparam logic [4:0] FN_TRANS_X  = 5'd2;
  localparam logic [4:0] FN_TRANS_Y  = 5'd3;
  localparam logic [4:0] FN_TRANS_Z  = 5'd4;
  localparam logic [4:0] FN_STR_X    = 5'd5;
  localparam logic [4:0] FN_STR_Y    = 5'd6;
  localparam logic [4:0] FN_STR_Z    = 5'd7;
  localparam logic [4:0] FN_ROT_X    = 5'd8;
  localparam logic [4:0] FN_ROT_Y    = 5'd9;
  localparam logic [4:0] FN_ROT_Z    = 5'd10;
  localparam logic [4:0] FN_SHR_XY   = 5'd11;
  localparam logic [4:0] FN_SHR_XZ   = 5'd12;
  localparam logic [4:0] FN_SHR_YZ   = 5'd13;
  localparam logic [4:0] FN_MIR_XY   = 5'd14;
  localparam logic [4:0] FN_MIR_XZ   = 5'd15;
  localparam logic [4:0] FN_MIR_YZ   = 5'd16;

  // Column index of the translation column in the 3x4 matrix
  localparam logic [1:0] COL_OFFSET  = 2'd3;
  localparam logic [1:0] LAST_IDX    = 2'd2;
  // Last of the four partial-product phases of one multiply
  localparam logic [1:0] LAST_PH     = 2'd3;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_INIT = 7'b0000010,
    ST_MUL  = 7'b0000100,
    ST_ACC  = 7'b0001000,
    ST_WR   = 7'b0010000,
    ST_CMT  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;    // latch point and build primitive matrix
    logic       ident;   // restore identity matrix
    logic       init;    // preset accumulator for current entry
    logic       mul;     // form one partial product
    logic       add;     // round product and accumulate
    logic       wr;      // saturate and store current entry
    logic       commit;  // copy composed matrix into place
    logic       outld;   // move point result into output register
    logic       point;   // current item maps a point
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] k;
    logic [1:0] ph;      // partial-product phase: bit 1 high coef half, bit 0 high value half
  } cmd_t;

endpackage

[design/atc_ctrl.sv]
// Controller state machine sequencing terms, entries and result handoff.
module atc_ctrl import atc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [4:0] func,
  output logic       out_valid,
  input  logic       out_ready,
  output cmd_t       cmd
);

  state_t     state, state_next;
  logic       point, point_next;
  logic [1:0] row, row_next;
  logic [1:0] col, col_next;
  logic [1:0] k, k_next;
  logic [1:0] ph, ph_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and command decode
  always_comb begin
    state_next = state;
    point_next = point;
    row_next   = row;
    col_next   = col;
    k_next     = k;
    ph_next    = ph;
    cmd        = '0;
    cmd.point  = point;
    cmd.row    = row;
    cmd.col    = col;
    cmd.k      = k;
    cmd.ph     = ph;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          row_next = '0;
          col_next = '0;
          k_next   = '0;
          ph_next  = '0;
          if (func == FN_POINT) begin
            point_next = 1'b1;
            state_next = ST_INIT;
          end else if (func == FN_IDENT) begin
            cmd.ident = 1'b1;
          end else if (func <= FN_MIR_YZ) begin
            point_next = 1'b0;
            state_next = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        k_next     = '0;
        ph_next    = '0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        if (ph == LAST_PH) begin
          ph_next    = '0;
          state_next = ST_ACC;
        end else begin
          ph_next = ph + 2'd1;
        end
      end
      ST_ACC: begin
        cmd.add = 1'b1;
        if (k == LAST_IDX) begin
          state_next = ST_WR;
        end else begin
          k_next     = k + 2'd1;
          state_next = ST_MUL;
        end
      end
      ST_WR: begin
        cmd.wr = 1'b1;
        if (point) begin
          if (row == LAST_IDX) begin
            state_next = ST_FIN;
          end else begin
            row_next   = row + 2'd1;
            state_next = ST_INIT;
          end
        end else if (col == COL_OFFSET) begin
          col_next = '0;
          if (row == LAST_IDX) begin
            state_next = ST_CMT;
          end else begin
            row_next   = row + 2'd1;
            state_next = ST_INIT;
          end
        end else begin
          col_next   = col + 2'd1;
          state_next = ST_INIT;
        end
      end
      ST_CMT: begin
        cmd.commit = 1'b1;
        state_next = ST_IDLE;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.outld  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      point     <= 1'b0;
      row       <= '0;
      col       <= '0;
      k         <= '0;
      ph        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      point <= point_next;
      row   <= row_next;
      col   <= col_next;
      k     <= k_next;
      ph    <= ph_next;
      if (cmd.outld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/atc_datapath.sv]
// Matrix storage, shared multiplier, rounding accumulator and saturation.
module atc_datapath import atc_pkg::*; #(
  parameter int COORD_WIDTH = 48,
  parameter int COEF_WIDTH  = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  input  logic [4:0]                    func,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic signed [COORD_WIDTH-1:0] shift_amount,
  input  logic signed [COEF_WIDTH-1:0]  factor_a,
  input  logic signed [COEF_WIDTH-1:0]  factor_b,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z
);

  localparam int VW = (COORD_WIDTH > COEF_WIDTH) ? COORD_WIDTH : COEF_WIDTH;
  localparam int PW = COEF_WIDTH + VW;
  localparam int AW = PW + 3;
  localparam int FB = COEF_WIDTH - 12;
  // Operand halves for the partial products
  localparam int CL  = COEF_WIDTH / 2;
  localparam int VL  = VW / 2;
  localparam int MA  = CL + 1;
  localparam int MB  = VL + 1;
  localparam int PPW = MA + MB;

  localparam logic signed [COEF_WIDTH-1:0] ONE  = COEF_WIDTH'(1) << FB;
  localparam logic signed [COEF_WIDTH-1:0] MONE = -ONE;
  localparam logic signed [COEF_WIDTH-1:0] CMAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic signed [COEF_WIDTH-1:0] CMIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};
  localparam logic signed [AW-1:0] RND    = AW'(1) <<< (FB - 1);
  localparam logic signed [AW-1:0] CF_MAX = (AW'(1) <<< (COEF_WIDTH - 1)) - AW'(1);
  localparam logic signed [AW-1:0] CF_MIN = -(AW'(1) <<< (COEF_WIDTH - 1));
  localparam logic signed [AW-1:0] CO_MAX = (AW'(1) <<< (COORD_WIDTH - 1)) - AW'(1);
  localparam logic signed [AW-1:0] CO_MIN = -(AW'(1) <<< (COORD_WIDTH - 1));

  logic signed [COEF_WIDTH-1:0]  lin [3][3];
  logic signed [COORD_WIDTH-1:0] off [3];
  logic signed [COEF_WIDTH-1:0]  nlin [3][3];
  logic signed [COORD_WIDTH-1:0] noff [3];
  logic signed [COEF_WIDTH-1:0]  dm [3][3];
  logic signed [COEF_WIDTH-1:0]  dm_next [3][3];
  logic signed [COORD_WIDTH-1:0] dt [3];
  logic signed [COORD_WIDTH-1:0] dt_next [3];
  logic signed [COORD_WIDTH-1:0] pos [3];
  logic signed [COORD_WIDTH-1:0] res [3];
  logic signed [PW-1:0]          prod;
  logic signed [AW-1:0]          acc;
  logic signed [AW-1:0]          acc_init;
  logic signed [AW-1:0]          rterm;
  logic signed [AW-1:0]          sat_hi, sat_lo, sat_val;
  logic signed [COEF_WIDTH-1:0]  coef_sel;
  logic signed [VW-1:0]          val_sel;
  logic signed [COEF_WIDTH-1:0]  nsin;
  logic signed [MA-1:0]          mul_a;
  logic signed [MB-1:0]          mul_b;
  logic signed [PPW-1:0]         pp;
  logic signed [PW-1:0]          pp_sh;

  // Primitive matrix for the command item
  always_comb begin
    nsin = (factor_b == CMIN) ? CMAX : -factor_b;
    for (int i = 0; i < 3; i++) begin
      dt_next[i] = '0;
      for (int j = 0; j < 3; j++) begin
        dm_next[i][j] = (i == j) ? ONE : '0;
      end
    end
    case (func)
      FN_TRANS_X: dt_next[0] = shift_amount;
      FN_TRANS_Y: dt_next[1] = shift_amount;
      FN_TRANS_Z: dt_next[2] = shift_amount;
      FN_STR_X:   dm_next[0][0] = factor_a;
      FN_STR_Y:   dm_next[1][1] = factor_a;
      FN_STR_Z:   dm_next[2][2] = factor_a;
      FN_ROT_X: begin
        dm_next[1][1] = factor_a; dm_next[1][2] = nsin;
        dm_next[2][1] = factor_b; dm_next[2][2] = factor_a;
      end
      FN_ROT_Y: begin
        dm_next[0][0] = factor_a; dm_next[0][2] = factor_b;
        dm_next[2][0] = nsin;     dm_next[2][2] = factor_a;
      end
      FN_ROT_Z: begin
        dm_next[0][0] = factor_a; dm_next[0][1] = nsin;
        dm_next[1][0] = factor_b; dm_next[1][1] = factor_a;
      end
      FN_SHR_XY: begin
        dm_next[0][2] = factor_a; dm_next[1][2] = factor_b;
      end
      FN_SHR_XZ: begin
        dm_next[0][1] = factor_a; dm_next[2][1] = factor_b;
      end
      FN_SHR_YZ: begin
        dm_next[1][0] = factor_a; dm_next[2][0] = factor_b;
      end
      FN_MIR_XY: dm_next[2][2] = MONE;
      FN_MIR_XZ: dm_next[1][1] = MONE;
      FN_MIR_YZ: dm_next[0][0] = MONE;
      default: ;
    endcase
  end

  // Operand selection for the current term
  always_comb begin
    if (cmd.point) begin
      coef_sel = lin[cmd.row][cmd.k];
      val_sel  = VW'(pos[cmd.k]);
    end else begin
      coef_sel = dm[cmd.row][cmd.k];
      if (cmd.col == COL_OFFSET) begin
        val_sel = VW'(off[cmd.k]);
      end else begin
        val_sel = VW'(lin[cmd.k][cmd.col]);
      end
    end
  end

  // One partial product per phase: low halves taken unsigned, high halves signed
  always_comb begin
    if (cmd.ph[1]) begin
      mul_a = MA'($signed(coef_sel[COEF_WIDTH-1:CL]));
    end else begin
      mul_a = $signed({1'b0, coef_sel[CL-1:0]});
    end
    if (cmd.ph[0]) begin
      mul_b = MB'($signed(val_sel[VW-1:VL]));
    end else begin
      mul_b = $signed({1'b0, val_sel[VL-1:0]});
    end
    pp = PPW'(mul_a) * PPW'(mul_b);
    case (cmd.ph)
      2'd0:    pp_sh = PW'(pp);
      2'd1:    pp_sh = PW'(pp) <<< VL;
      2'd2:    pp_sh = PW'(pp) <<< CL;
      default: pp_sh = PW'(pp) <<< (CL + VL);
    endcase
  end

  // Accumulator preset: translation where one applies
  always_comb begin
    if (cmd.point) begin
      acc_init = AW'(off[cmd.row]);
    end else if (cmd.col == COL_OFFSET) begin
      acc_init = AW'(dt[cmd.row]);
    end else begin
      acc_init = '0;
    end
  end

  // Rounded term and saturation to the target format
  assign rterm = (AW'(prod) + RND) >>> FB;

  always_comb begin
    if (cmd.point || (cmd.col == COL_OFFSET)) begin
      sat_hi = CO_MAX;
      sat_lo = CO_MIN;
    end else begin
      sat_hi = CF_MAX;
      sat_lo = CF_MIN;
    end
    if (acc > sat_hi) begin
      sat_val = sat_hi;
    end else if (acc < sat_lo) begin
      sat_val = sat_lo;
    end else begin
      sat_val = acc;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos[0] <= pos_x;
      pos[1] <= pos_y;
      pos[2] <= pos_z;
      dm     <= dm_next;
      dt     <= dt_next;
    end
    if (cmd.init) begin
      acc <= acc_init;
    end else if (cmd.add) begin
      acc <= acc + rterm;
    end
    // product built up over four phases; the sum wraps at PW bits but ends exact
    if (cmd.mul) begin
      if (cmd.ph == '0) begin
        prod <= pp_sh;
      end else begin
        prod <= prod + pp_sh;
      end
    end
    if (cmd.wr) begin
      if (cmd.point) begin
        res[cmd.row] <= COORD_WIDTH'(sat_val);
      end else if (cmd.col == COL_OFFSET) begin
        noff[cmd.row] <= COORD_WIDTH'(sat_val);
      end else begin
        nlin[cmd.row][cmd.col] <= COEF_WIDTH'(sat_val);
      end
    end
    if (cmd.outld) begin
      out_x <= res[0];
      out_y <= res[1];
      out_z <= res[2];
    end
  end

  // Held matrix: reset and identity command give the identity
  always_ff @(posedge clk) begin
    if (rst || cmd.ident) begin
      for (int i = 0; i < 3; i++) begin
        off[i] <= '0;
        for (int j = 0; j < 3; j++) begin
          lin[i][j] <= (i == j) ? ONE : '0;
        end
      end
    end else if (cmd.commit) begin
      lin <= nlin;
      off <= noff;
    end
  end

endmodule

[design/affine_transform_composer.sv]
// Top level of the 3-D affine transform composer.
// Holds a 3x4 affine matrix (Q12.28 linear part, Q32.16 translation) that
// starts as the identity. func 0 maps a point and returns a result item;
// if the previous result still waits in the output register the block
// holds in its last step until that result is taken. Commands 2-16
// left-multiply the matrix by a primitive and return nothing; identity and
// unused codes never leave the idle state. All terms go through one shared
// multiplier that builds each product from four half-width partial
// products, one per step, and a further step rounds and accumulates the
// term; each entry adds a preset step before its terms and a store step
// after them. A point computes 3 entries and a command 12, and each ends
// with a final commit or output step. One item is worked at a time; a
// finished point waits in the output register while the next item is
// taken.
module affine_transform_composer import atc_pkg::*; #(
  parameter int COORD_WIDTH = 48,
  parameter int COEF_WIDTH  = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [4:0]                    func,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic signed [COORD_WIDTH-1:0] shift_amount,
  input  logic signed [COEF_WIDTH-1:0]  factor_a,
  input  logic signed [COEF_WIDTH-1:0]  factor_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z
);

  cmd_t cmd;

  atc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  atc_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .COEF_WIDTH  (COEF_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .func         (func),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .shift_amount (shift_amount),
    .factor_a     (factor_a),
    .factor_b     (factor_b),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z)
  );

endmodule

[design/atc_checker.sv]
// Port-level checker for the affine transform composer, with its bind.
module atc_checker import atc_pkg::*; #(
  parameter int COORD_WIDTH = 48
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [4:0]             func,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] out_x
);

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x))
    else $error("result item dropped or changed while stalled");

  // A command item never produces a result right away
  a_cmd_no_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (func != FN_POINT) && !out_valid |=> !out_valid)
    else $error("command item produced a result");

  // A point item occupies the block
  a_point_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (func == FN_POINT) |=> !in_ready)
    else $error("input taken while a point is in work");

endmodule

bind affine_transform_composer atc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_atc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .func      (func),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_x     (out_x)
);
